// ----- src/plti_pkg.sv -----
// Package for the piecewise-linear table interpolator.
// Holds table sizing, field widths and the function and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plti_pkg;

  localparam int MAX_NODES = 64;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;

  localparam int IN_DATA_W  = KEY_W + VAL_W;
  localparam int OUT_DATA_W = VAL_W;

  // One quotient bit per divider step
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ----- src/piecewise_linear_table_interp_unit.sv -----
// Piecewise-linear table interpolator: node table, binary search and
// an iterative divider under one sequencer.
// Depends on plti_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Slave channel s_axis_*: one transaction per command. tuser carries the
//   function (append node, query, clear table); tdata carries the key and,
//   for an append, the node value. Master channel m_axis_*: exactly one
//   transaction per command, tdata the value, tuser the status.
//   The block takes one command at a time; s_axis_tready_o is low from
//   acceptance until the result has been loaded into the output register.
//   Append, clear and an empty-table query go from acceptance straight to
//   the response state. A query outside the table's key range passes the
//   low-end check and, for a key above the first node, the high-end check.
//   An interior query runs both end checks, the binary-search steps, two
//   table reads, the restoring divider that forms the fraction, a multiply
//   and an add, then loads the output register; a bracket span of zero or
//   less skips to the lower value. The divider dominates query latency.
//   Reset empties the table; node storage itself is not cleared.
//   A stall on m_axis_tready_i holds the result; the block may accept the
//   next command meanwhile and parks its next result until the output
//   register frees.
module piecewise_linear_table_interp_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [31:0] key, [63:32] node_value
  input  wire logic [plti_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] func
  input  wire logic [plti_pkg::FUNC_W-1:0]     s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [31:0] value
  output logic [plti_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // [1:0] status
  output logic [plti_pkg::STAT_W-1:0]          m_axis_tuser_o
);

  localparam int KW = plti_pkg::KEY_W;
  localparam int VW = plti_pkg::VAL_W;
  localparam int AW = plti_pkg::ADDR_W;
  localparam int CW = plti_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_LO,
    S_CHK_HI,
    S_SEARCH,
    S_GET_L,
    S_GET_H,
    S_DIV,
    S_MUL,
    S_ADD,
    S_RESP
  } state_e;

  // Node storage
  logic [KW-1:0] key_mem [plti_pkg::MAX_NODES];
  logic [VW-1:0] val_mem [plti_pkg::MAX_NODES];

  state_e                          state_q, state_d;
  logic [CW-1:0]                   count_q, count_d;
  logic                            out_valid_q, out_valid_d;
  logic [VW-1:0]                   out_val_q, out_val_d;
  plti_pkg::status_e               out_st_q, out_st_d;
  logic [VW-1:0]                   res_val_q, res_val_d;
  plti_pkg::status_e               res_st_q, res_st_d;
  logic [KW-1:0]                   qkey_q, qkey_d;
  logic [CW-1:0]                   lo_q, lo_d, hi_q, hi_d;
  logic [KW-1:0]                   kl_q, kl_d;
  logic [VW-1:0]                   vl_q, vl_d, vh_q, vh_d;
  logic [KW-1:0]                   span_q, span_d;
  logic [KW:0]                     rem_q, rem_d;
  logic [VW-1:0]                   quot_q, quot_d;
  logic [plti_pkg::DIV_CNT_W-1:0]  div_cnt_q, div_cnt_d;
  logic [2*VW-1:0]                 prod_q, prod_d;

  logic [KW-1:0]                   rd_key_q;
  logic [VW-1:0]                   rd_val_q;
  logic [AW-1:0]                   rd_addr;
  logic                            mem_we;
  logic [AW-1:0]                   wr_addr;

  logic                            in_fire;
  logic                            out_free;
  plti_pkg::func_e                 in_func;
  logic [KW-1:0]                   in_key;
  logic [VW-1:0]                   in_val;

  logic                            key_lt;
  logic [CW-1:0]                   mid_cur, lo_n, hi_n, mid_n, h_sel, cnt_m1;
  logic signed [KW:0]              kh_ext, kl_ext, q_ext, span_s, d_s;
  logic [KW-1:0]                   d_sat;
  logic                            div_ge;
  logic [KW:0]                     rem_sub;
  logic                            val_up;
  logic [VW-1:0]                   val_diff;
  logic [VW-1:0]                   incr;

  assign in_func  = plti_pkg::func_e'(s_axis_tuser_i);
  assign in_key   = s_axis_tdata_i[KW-1:0];
  assign in_val   = s_axis_tdata_i[KW+VW-1:KW];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign wr_addr  = count_q[AW-1:0];
  assign cnt_m1   = count_q - CW'(1);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = out_st_q;

  // Search datapath
  assign key_lt  = $signed(rd_key_q) < $signed(qkey_q);
  assign mid_cur = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_n    = key_lt ? mid_cur + CW'(1) : lo_q;
  assign hi_n    = key_lt ? hi_q : mid_cur;
  assign mid_n   = lo_n + ((hi_n - lo_n) >> 1);

  always_comb begin
    if (hi_n < CW'(1)) begin
      h_sel = CW'(1);
    end else if (hi_n > cnt_m1) begin
      h_sel = cnt_m1;
    end else begin
      h_sel = hi_n;
    end
  end

  // Bracket arithmetic, exact in 33 bits
  assign kh_ext = $signed({rd_key_q[KW-1], rd_key_q});
  assign kl_ext = $signed({kl_q[KW-1], kl_q});
  assign q_ext  = $signed({qkey_q[KW-1], qkey_q});
  assign span_s = kh_ext - kl_ext;
  assign d_s    = q_ext - kl_ext;

  always_comb begin
    if (d_s[KW]) begin
      d_sat = '0;
    end else if (d_s > span_s) begin
      d_sat = span_s[KW-1:0];
    end else begin
      d_sat = d_s[KW-1:0];
    end
  end

  // Restoring divider step
  assign div_ge  = rem_q >= {1'b0, span_q};
  assign rem_sub = div_ge ? rem_q - {1'b0, span_q} : rem_q;

  assign val_up   = vh_q >= vl_q;
  assign val_diff = val_up ? vh_q - vl_q : vl_q - vh_q;
  assign incr     = prod_q[2*VW-2:VW-1];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    qkey_d      = qkey_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    kl_d        = kl_q;
    vl_d        = vl_q;
    vh_d        = vh_q;
    span_d      = span_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    div_cnt_d   = div_cnt_q;
    prod_d      = prod_q;
    rd_addr     = '0;
    mem_we      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_val_d = '0;
          res_st_d  = plti_pkg::STAT_OK;
          qkey_d    = in_key;
          state_d   = S_RESP;
          case (in_func)
            plti_pkg::FUNC_APPEND: begin
              if (count_q >= CW'(plti_pkg::MAX_NODES)) begin
                res_st_d = plti_pkg::STAT_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            plti_pkg::FUNC_QUERY: begin
              if (count_q == '0) begin
                res_st_d = plti_pkg::STAT_EMPTY;
              end else begin
                rd_addr = '0;
                state_d = S_CHK_LO;
              end
            end
            plti_pkg::FUNC_CLEAR: begin
              count_d = '0;
            end
            default: begin
              // unused selector: no operation
            end
          endcase
        end
      end

      S_CHK_LO: begin
        if (!key_lt) begin
          res_val_d = rd_val_q;
          state_d   = S_RESP;
        end else begin
          rd_addr = cnt_m1[AW-1:0];
          state_d = S_CHK_HI;
        end
      end

      S_CHK_HI: begin
        if (!key_lt && rd_key_q != qkey_q) begin
          // interior: two or more nodes are guaranteed here
          lo_d    = '0;
          hi_d    = count_q;
          rd_addr = AW'(count_q >> 1);
          state_d = S_SEARCH;
        end else begin
          res_val_d = rd_val_q;
          state_d   = S_RESP;
        end
      end

      S_SEARCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          rd_addr = mid_n[AW-1:0];
        end else begin
          hi_d    = h_sel;
          rd_addr = AW'(h_sel - CW'(1));
          state_d = S_GET_L;
        end
      end

      S_GET_L: begin
        kl_d    = rd_key_q;
        vl_d    = rd_val_q;
        rd_addr = hi_q[AW-1:0];
        state_d = S_GET_H;
      end

      S_GET_H: begin
        vh_d = rd_val_q;
        if (span_s[KW] || span_s == '0) begin
          res_val_d = vl_q;
          state_d   = S_RESP;
        end else begin
          span_d    = span_s[KW-1:0];
          rem_d     = {1'b0, d_sat};
          quot_d    = '0;
          div_cnt_d = '0;
          state_d   = S_DIV;
        end
      end

      S_DIV: begin
        quot_d    = {quot_q[VW-2:0], div_ge};
        rem_d     = {rem_sub[KW-1:0], 1'b0};
        div_cnt_d = div_cnt_q + plti_pkg::DIV_CNT_W'(1);
        if (div_cnt_q == plti_pkg::DIV_CNT_W'(plti_pkg::DIV_STEPS - 1)) begin
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        prod_d  = (2*VW)'(quot_q) * (2*VW)'(val_diff);
        state_d = S_ADD;
      end

      S_ADD: begin
        res_val_d = val_up ? vl_q + incr : vl_q - incr;
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    qkey_q    <= qkey_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    kl_q      <= kl_d;
    vl_q      <= vl_d;
    vh_q      <= vh_d;
    span_q    <= span_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    div_cnt_q <= div_cnt_d;
    prod_q    <= prod_d;
  end

  // Node memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[wr_addr] <= in_key;
      val_mem[wr_addr] <= in_val;
    end
    rd_key_q <= key_mem[rd_addr];
    rd_val_q <= val_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- tb/tb_piecewise_linear_table_interp_unit.sv -----
// Self-checking testbench for piecewise_linear_table_interp_unit: directed table then
// random append/query/clear/unused-selector sequences under varying backpressure, checked by a predictor.
// Depends on plti_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interp_unit;
  import plti_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;  // unused selector, does nothing
  localparam int N_DIRECTED     = 23;
  localparam int RAND_ITEMS     = 1100;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int MAX_SEQ_NODES  = 70;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    status_e          status;
  } result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] cmd;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  nval;
    logic              typed;
    logic [VAL_W-1:0]  value;
    status_e           status;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  s_valid;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_data;
  logic [FUNC_W-1:0]     s_user;
  logic                  m_axis_tvalid_o;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [STAT_W-1:0]     m_axis_tuser_o;

  // Predictor copy of the node table
  logic signed [KEY_W-1:0] tbl_key [0:MAX_NODES-1];
  logic [VAL_W-1:0]        tbl_val [0:MAX_NODES-1];
  int unsigned             node_cnt;

  result_t owed[$];
  int      fails, results_seen, cmds_sent;
  int      n_append, n_refused, n_query, n_empty, n_clear, n_nop;
  int      snd_idle_pct, rcv_stall_pct;
  int      holdoff_reqs, holdoff_seen, holdoff_left;

  row_t directed_rows [0:N_DIRECTED-1];

  piecewise_linear_table_interp_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Clamped lower-bound search plus truncated linear interpolation
  function automatic logic [VAL_W-1:0] interp_at(logic signed [KEY_W-1:0] q);
    int unsigned n, lo, hi, mid, h, l;
    longint      span, d;
    logic [63:0] frac, dd, sp, vl, vh;
    n = node_cnt;
    if (q <= tbl_key[0]) return tbl_val[0];
    if (q >= tbl_key[n-1]) return tbl_val[n-1];
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (tbl_key[mid] < q) lo = mid + 1;
      else hi = mid;
    end
    h = hi;
    if (h < 1) h = 1;
    if (h > n - 1) h = n - 1;
    l = h - 1;
    span = longint'(tbl_key[h]) - longint'(tbl_key[l]);
    if (span <= 0) return tbl_val[l];
    d = longint'(q) - longint'(tbl_key[l]);
    if (d < 0) d = 0;
    if (d > span) d = span;
    dd   = d;
    sp   = span;
    frac = (dd << 31) / sp;
    vl   = tbl_val[l];
    vh   = tbl_val[h];
    if (vh >= vl) return VAL_W'(vl + ((frac * (vh - vl)) >> 31));
    return VAL_W'(vl - ((frac * (vl - vh)) >> 31));
  endfunction

  // Apply one command to the predictor table and return the result it owes
  function automatic result_t table_response(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                             logic [VAL_W-1:0] v);
    result_t r;
    r.value  = '0;
    r.status = STAT_OK;
    case (f)
      FUNC_APPEND: begin
        n_append++;
        if (node_cnt >= MAX_NODES) begin
          r.status = STAT_FULL;
          n_refused++;
        end else begin
          tbl_key[node_cnt] = k;
          tbl_val[node_cnt] = v;
          node_cnt++;
        end
      end
      FUNC_QUERY: begin
        n_query++;
        if (node_cnt == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
        end else begin
          r.value = interp_at(k);
        end
      end
      FUNC_CLEAR: begin
        n_clear++;
        node_cnt = 0;
      end
      default: n_nop++;
    endcase
    return r;
  endfunction

  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                          input logic [VAL_W-1:0] v, input bit typed,
                          input logic [VAL_W-1:0] t_val, input status_e t_stat);
    int      gap;
    bit      took;
    result_t r;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {v, k};
    s_user  <= f;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = s_axis_tready_o;
      @(posedge clk);
    end
    r = table_response(f, k, v);
    if (typed) begin
      r.value  = t_val;
      r.status = t_stat;
    end
    owed = {owed, r};
    cmds_sent++;
  endtask

  // Receiver readiness; a requested hold-off is counted down here
  always @(posedge clk) begin
    if (holdoff_reqs != holdoff_seen) begin
      holdoff_seen <= holdoff_seen + 1;
      holdoff_left <= HOLDOFF_CYCLES;
      m_ready      <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      m_ready      <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Sample outputs mid-cycle; they hold until the next rising edge
  always @(negedge clk) begin : result_check
    result_t want;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      if (owed.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected transaction: value %h status %0d",
                   m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        want = owed.pop_front();
        results_seen++;
        if (m_axis_tdata_o !== want.value || m_axis_tuser_o !== want.status) begin
          fails++;
          if (fails <= 10)
            $display("result %0d: expected value %h status %0d, got value %h status %0d",
                     results_seen, want.value, want.status, m_axis_tdata_o, m_axis_tuser_o);
        end
      end
    end
  end

  initial begin : stimulus
    logic signed [KEY_W-1:0] seq_keys [0:MAX_SEQ_NODES-1];
    logic signed [KEY_W-1:0] tmp;
    logic [KEY_W-1:0]        q;
    longint                  lo_k, hi_k, gapw;
    int                      seq, phase, n_nodes, n_q, i, j, pick, idx;

    rst_n         <= 1'b0;
    s_valid       <= 1'b0;
    s_data        <= '0;
    s_user        <= FUNC_APPEND;
    snd_idle_pct  = 0;
    rcv_stall_pct <= 0;
    holdoff_reqs  <= 0;
    node_cnt      = 0;

    directed_rows = '{
      '{FUNC_QUERY,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EMPTY},
      '{FUNC_NOP,    32'h1234_5678, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000, STAT_OK},
      '{FUNC_APPEND, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, STAT_OK},
      '{FUNC_APPEND, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_OK},
      '{FUNC_APPEND, 32'h7FFF_FFFF, 32'h1000_0000, 1'b1, 32'h0000_0000, STAT_OK},
      '{FUNC_QUERY,  32'h8000_0000, 32'h0,         1'b1, 32'h0000_0000, STAT_OK},
      '{FUNC_QUERY,  32'h7FFF_FFFF, 32'h0,         1'b1, 32'h1000_0000, STAT_OK},
      '{FUNC_QUERY,  32'h0000_0000, 32'h0,         1'b0, 32'h0,         STAT_OK},
      '{FUNC_QUERY,  32'hC000_0000, 32'h0,         1'b0, 32'h0,         STAT_OK},
      '{FUNC_QUERY,  32'h4000_0000, 32'h0,         1'b0, 32'h0,         STAT_OK},
      '{FUNC_QUERY,  32'h7FFF_FFFE, 32'h0,         1'b0, 32'h0,         STAT_OK},
      '{FUNC_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_OK},
      '{FUNC_QUERY,  32'h5555_5555, 32'h0,         1'b1, 32'h0000_0000, STAT_EMPTY},
      '{FUNC_APPEND, 32'h0000_0005, 32'h0000_1234, 1'b1, 32'h0000_0000, STAT_OK},
      '{FUNC_QUERY,  32'h8000_0000, 32'h0,         1'b1, 32'h0000_1234, STAT_OK},
      '{FUNC_QUERY,  32'h7FFF_FFFF, 32'h0,         1'b1, 32'h0000_1234, STAT_OK},
      '{FUNC_APPEND, 32'h0000_0005, 32'h0000_9999, 1'b1, 32'h0000_0000, STAT_OK},
      '{FUNC_APPEND, 32'h0000_0100, 32'h0000_5000, 1'b1, 32'h0000_0000, STAT_OK},
      '{FUNC_QUERY,  32'h0000_0006, 32'h0,         1'b0, 32'h0,         STAT_OK},
      '{FUNC_APPEND, 32'h0000_0080, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000, STAT_OK},
      '{FUNC_QUERY,  32'h0000_0090, 32'h0,         1'b0, 32'h0,         STAT_OK},
      '{FUNC_QUERY,  32'h0000_0020, 32'h0,         1'b0, 32'h0,         STAT_OK},
      '{FUNC_CLEAR,  32'h0,         32'h0,         1'b1, 32'h0000_0000, STAT_OK}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++)
      send_cmd(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].nval,
               directed_rows[i].typed, directed_rows[i].value, directed_rows[i].status);

    for (seq = 0; cmds_sent < N_DIRECTED + RAND_ITEMS; seq++) begin
      // Rotate through no idling, sender idle, receiver stall, and both
      phase = seq % 4;
      snd_idle_pct  = (phase == 1) ? 83 : (phase == 3) ? 25 : 0;
      rcv_stall_pct <= (phase == 2) ? 83 : (phase == 3) ? 25 : 0;
      if (seq == 4) holdoff_reqs <= holdoff_reqs + 1;

      if (seq == 0 || $urandom_range(99) < 80) begin
        if (seq == 0 || $urandom_range(9) != 0)
          send_cmd(FUNC_CLEAR, $urandom, $urandom, 1'b0, '0, STAT_OK);
        n_nodes = (seq == 0 || $urandom_range(99) < 12) ? $urandom_range(58, MAX_SEQ_NODES)
                                                        : $urandom_range(1, 12);
        for (i = 0; i < n_nodes; i++) begin
          if (i > 0 && $urandom_range(9) == 0) seq_keys[i] = seq_keys[i-1];
          else if ($urandom_range(1) == 0) seq_keys[i] = $urandom;
          else seq_keys[i] = $signed(KEY_W'($urandom_range(4096))) - 2048;
        end
        // Sort ascending, signed
        for (i = 1; i < n_nodes; i++) begin
          tmp = seq_keys[i];
          j = i;
          while (j > 0 && seq_keys[j-1] > tmp) begin
            seq_keys[j] = seq_keys[j-1];
            j--;
          end
          seq_keys[j] = tmp;
        end
        for (i = 0; i < n_nodes; i++)
          send_cmd(FUNC_APPEND, seq_keys[i], $urandom, 1'b0, '0, STAT_OK);

        n_q = $urandom_range(3, 12);
        for (i = 0; i < n_q; i++) begin
          pick = $urandom_range(9);
          if (pick <= 5 && n_nodes > 1) begin
            idx  = $urandom_range(n_nodes - 2);
            lo_k = longint'(seq_keys[idx]);
            hi_k = longint'(seq_keys[idx+1]);
            gapw = hi_k - lo_k;
            q = (gapw > 0) ? KEY_W'(lo_k + longint'({32'd0, $urandom} % gapw)) : KEY_W'(lo_k);
          end else if (pick <= 6) begin
            q = seq_keys[$urandom_range(n_nodes - 1)];
          end else if (pick == 7) begin
            q = $urandom;
          end else if (pick == 8) begin
            q = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          end
          if (pick == 9) send_cmd(FUNC_NOP, $urandom, $urandom, 1'b0, '0, STAT_OK);
          else send_cmd(FUNC_QUERY, q, $urandom, 1'b0, '0, STAT_OK);
        end
      end else begin
        // Noise: any selector, arbitrary fields, possibly unsorted keys
        repeat ($urandom_range(1, 6))
          send_cmd(FUNC_W'($urandom_range(3)), $urandom, $urandom, 1'b0, '0, STAT_OK);
      end
    end
    s_valid <= 1'b0;

    while (owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands: %0d appends (%0d refused when full), %0d queries",
             cmds_sent, n_append, n_refused, n_query);
    $display("  (%0d on an empty table), %0d clears, %0d unused selectors; %0d results checked",
             n_empty, n_clear, n_nop, results_seen);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fails);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/plti_pkg.sv
src/piecewise_linear_table_interp_unit.sv
tb/tb_piecewise_linear_table_interp_unit.sv
